@@ rtl/single_source_shortest_paths_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the shortest path core
// Immediate-consequence and next-cycle implication checks with async reset.
// ----------------------------------------------------------------------------
`ifndef SINGLE_SOURCE_SHORTEST_PATHS_CORE_ASSERT_SVH
`define SINGLE_SOURCE_SHORTEST_PATHS_CORE_ASSERT_SVH

// same-cycle implication
`define SSSP_ASSERT_NOW(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sssp: same-cycle check failed");

// next-cycle implication
`define SSSP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sssp: next-cycle check failed");

`endif

@@ rtl/sssp_pkg.sv @@
// ----------------------------------------------------------------------------
// sssp_pkg
// Shared widths, action codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sssp_pkg;

	localparam int VTX_W        = 4;
	localparam int MAX_VERTICES = 16;
	localparam int CNT_W        = 5;
	localparam int DIST_W       = 24;
	localparam int WEIGHT_W     = 16;
	localparam int SUM_W        = DIST_W + 1;
	localparam int ACT_W        = 2;
	localparam int IN_TDATA_W   = 32;
	localparam int OUT_TDATA_W  = 32;

	localparam logic [ACT_W-1:0] ACT_ADD   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_QUERY = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

	// saturation limits, full-precision and stored
	localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'((2 ** (DIST_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SUM_LO = SUM_W'(-(2 ** (DIST_W - 1)));
	localparam logic [DIST_W-1:0] DIST_HI = {1'b0, {(DIST_W - 1){1'b1}}};
	localparam logic [DIST_W-1:0] DIST_LO = {1'b1, {(DIST_W - 1){1'b0}}};

	typedef struct packed {
		logic             latch;
		logic             clear;
		logic             add_lo;
		logic             add_hi;
		logic             init;
		logic             clr_improved;
		logic             issue;
		logic             check;
		logic             out_sel;
		logic             out_load;
		logic             neg_load;
		logic             last;
		logic [VTX_W-1:0] out_idx;
	} sssp_cmd_t;

	typedef struct packed {
		logic             room;
		logic             scan_more;
		logic             improved;
		logic             out_free;
		logic [CNT_W-1:0] n_eff;
	} sssp_status_t;

endpackage

@@ rtl/sssp_dp.sv @@
// ----------------------------------------------------------------------------
// sssp_dp
// Edge table, distance memory, relaxation pipeline and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "single_source_shortest_paths_core_assert.svh"

module sssp_dp import sssp_pkg::*; #(
	parameter int MAX_DIRECTED_EDGES = 128,
	localparam int AW = $clog2(MAX_DIRECTED_EDGES),
	localparam int EW = $clog2(MAX_DIRECTED_EDGES + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CNT_W-1:0]         cfg_wdata,
	input  logic [VTX_W-1:0]         first_vertex,
	input  logic [VTX_W-1:0]         second_vertex,
	input  logic [WEIGHT_W-1:0]      weight,
	input  logic [VTX_W-1:0]         source_vertex,
	input  sssp_cmd_t                cmd,
	input  logic [EW-1:0]            edge_idx,
	output sssp_status_t             st,
	input  logic                     m_tready,
	output logic                     m_tvalid,
	output logic [VTX_W-1:0]         out_vertex,
	output logic [DIST_W-1:0]        out_distance,
	output logic                     out_reachable,
	output logic                     out_negative_cycle,
	output logic                     out_last
);

	localparam int ENT_W = 2 * VTX_W + WEIGHT_W;

	logic [CNT_W-1:0]    vc_q;
	logic [CNT_W-1:0]    n_eff;
	logic [EW-1:0]       edge_total_q;

	logic [VTX_W-1:0]    fa_q, fb_q, src_q;
	logic [WEIGHT_W-1:0] w_q;

	logic [ENT_W-1:0]    edge_mem [MAX_DIRECTED_EDGES];
	logic [EW-1:0]       ew_addr;
	logic [ENT_W-1:0]    ew_data;
	logic [ENT_W-1:0]    ent_s1;
	logic                valid_s1;

	logic                       valid_s2;
	logic [VTX_W-1:0]           tail_s2, head_s2;
	logic signed [WEIGHT_W-1:0] w_s2;

	logic [DIST_W-1:0]   dist_mem [MAX_VERTICES];
	logic [VTX_W-1:0]    rd_addr_a;
	logic [DIST_W-1:0]   rd_a_s2, rd_b_s2;
	logic                dist_we;
	logic [VTX_W-1:0]    dw_addr;
	logic [DIST_W-1:0]   dw_data;

	logic                wr_valid_q;
	logic [VTX_W-1:0]    wr_addr_q;
	logic [DIST_W-1:0]   wr_data_q;

	logic [MAX_VERTICES-1:0] mask_q;
	logic                    improved_q;

	logic signed [DIST_W-1:0] dt, dh;
	logic signed [SUM_W-1:0]  sum;
	logic [DIST_W-1:0]        sat;
	logic                     in_range, relax, relax_we;

	logic m_tvalid_q;

	// effective vertex count, clamped to 1..MAX_VERTICES
	always_comb begin
		if (vc_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (vc_q > CNT_W'(MAX_VERTICES)) begin
			n_eff = CNT_W'(MAX_VERTICES);
		end else begin
			n_eff = vc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q         <= CNT_W'(MAX_VERTICES);
			edge_total_q <= '0;
		end else begin
			if (cfg_we) vc_q <= cfg_wdata;
			if (cmd.clear) begin
				edge_total_q <= '0;
			end else if (cmd.add_hi) begin
				edge_total_q <= edge_total_q + EW'(2);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			fa_q  <= first_vertex;
			fb_q  <= second_vertex;
			w_q   <= weight;
			src_q <= source_vertex;
		end
	end

	// edge table: {weight, head, tail}
	assign ew_addr = edge_total_q + EW'(cmd.add_hi);
	assign ew_data = cmd.add_hi ? {w_q, fa_q, fb_q} : {w_q, fb_q, fa_q};

	always_ff @(posedge clk) begin
		if (cmd.add_lo || cmd.add_hi) edge_mem[ew_addr[AW-1:0]] <= ew_data;
		ent_s1 <= edge_mem[edge_idx[AW-1:0]];
	end

	// distance memory, two registered read ports
	assign rd_addr_a = cmd.out_sel ? cmd.out_idx : ent_s1[VTX_W-1:0];

	always_ff @(posedge clk) begin
		if (dist_we) dist_mem[dw_addr] <= dw_data;
		rd_a_s2 <= dist_mem[rd_addr_a];
		rd_b_s2 <= dist_mem[ent_s1[2*VTX_W-1:VTX_W]];
	end

	always_ff @(posedge clk) begin
		tail_s2   <= ent_s1[VTX_W-1:0];
		head_s2   <= ent_s1[2*VTX_W-1:VTX_W];
		w_s2      <= ent_s1[ENT_W-1:2*VTX_W];
		wr_addr_q <= dw_addr;
		wr_data_q <= dw_data;
	end

	// forward the write of the previous cycle, missed by the registered read
	assign dt = (wr_valid_q && wr_addr_q == tail_s2) ? wr_data_q : rd_a_s2;
	assign dh = (wr_valid_q && wr_addr_q == head_s2) ? wr_data_q : rd_b_s2;
	assign sum = SUM_W'(dt) + SUM_W'(w_s2);

	always_comb begin
		if (sum > SUM_HI) begin
			sat = DIST_HI;
		end else if (sum < SUM_LO) begin
			sat = DIST_LO;
		end else begin
			sat = sum[DIST_W-1:0];
		end
	end

	assign in_range = ({1'b0, tail_s2} < n_eff) && ({1'b0, head_s2} < n_eff);
	assign relax    = valid_s2 && in_range && mask_q[tail_s2] &&
	                  (!mask_q[head_s2] || sum < SUM_W'(dh));
	assign relax_we = relax && !cmd.check;

	assign dist_we = cmd.init || relax_we;
	assign dw_addr = cmd.init ? src_q : head_s2;
	assign dw_data = cmd.init ? '0 : sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			wr_valid_q <= 1'b0;
			mask_q     <= '0;
			improved_q <= 1'b0;
		end else begin
			valid_s1   <= cmd.issue;
			valid_s2   <= valid_s1;
			wr_valid_q <= relax_we;
			if (cmd.init) begin
				mask_q <= ({1'b0, src_q} < n_eff) ? (MAX_VERTICES'(1) << src_q) : '0;
			end else if (relax_we) begin
				mask_q[head_s2] <= 1'b1;
			end
			if (cmd.clr_improved) begin
				improved_q <= 1'b0;
			end else if (relax) begin
				improved_q <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load || cmd.neg_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_vertex         <= cmd.out_idx;
			out_distance       <= mask_q[cmd.out_idx] ? rd_a_s2 : '0;
			out_reachable      <= mask_q[cmd.out_idx];
			out_negative_cycle <= 1'b0;
			out_last           <= cmd.last;
		end else if (cmd.neg_load) begin
			out_vertex         <= src_q;
			out_distance       <= '0;
			out_reachable      <= 1'b0;
			out_negative_cycle <= 1'b1;
			out_last           <= 1'b1;
		end
	end

	assign m_tvalid     = m_tvalid_q;
	assign st.room      = ({1'b0, edge_total_q} + (EW + 1)'(2)) <=
	                      (EW + 1)'(MAX_DIRECTED_EDGES);
	assign st.scan_more = edge_idx < edge_total_q;
	assign st.improved  = improved_q;
	assign st.out_free  = !m_tvalid_q || m_tready;
	assign st.n_eff     = n_eff;

	`SSSP_ASSERT_NOW(a_total_bound, clk, arst_n, 1'b1, edge_total_q <= EW'(MAX_DIRECTED_EDGES))
	`SSSP_ASSERT_NEXT(a_seed_single, clk, arst_n, cmd.init, $onehot0(mask_q))
	`SSSP_ASSERT_NOW(a_relax_from_reached, clk, arst_n, relax_we, mask_q[tail_s2])

endmodule

@@ rtl/sssp_ctrl.sv @@
// ----------------------------------------------------------------------------
// sssp_ctrl
// Sequencer: edge insert, relaxation rounds, check pass and result emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "single_source_shortest_paths_core_assert.svh"

module sssp_ctrl import sssp_pkg::*; #(
	parameter int MAX_DIRECTED_EDGES = 128,
	localparam int EW = $clog2(MAX_DIRECTED_EDGES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [ACT_W-1:0] action,
	input  sssp_status_t     st,
	output sssp_cmd_t        cmd,
	output logic [EW-1:0]    edge_idx
);

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b00_0000_0001,
		ST_ADD_LO = 10'b00_0000_0010,
		ST_ADD_HI = 10'b00_0000_0100,
		ST_INIT   = 10'b00_0000_1000,
		ST_SCAN   = 10'b00_0001_0000,
		ST_DRAIN  = 10'b00_0010_0000,
		ST_DECIDE = 10'b00_0100_0000,
		ST_OUT_RD = 10'b00_1000_0000,
		ST_OUT_WR = 10'b01_0000_0000,
		ST_NEG    = 10'b10_0000_0000
	} state_t;

	state_t           state_q, state_d;
	logic [EW-1:0]    edge_idx_q, edge_idx_d;
	logic [CNT_W-1:0] round_q, round_d;
	logic             check_q, check_d;
	logic [VTX_W-1:0] out_idx_q, out_idx_d;
	logic             accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign edge_idx = edge_idx_q;

	always_comb begin
		state_d      = state_q;
		edge_idx_d   = edge_idx_q;
		round_d      = round_q;
		check_d      = check_q;
		out_idx_d    = out_idx_q;
		cmd          = '0;
		cmd.check    = check_q;
		cmd.out_idx  = out_idx_q;
		cmd.out_sel  = (state_q == ST_OUT_RD) || (state_q == ST_OUT_WR);
		cmd.last     = ({1'b0, out_idx_q} == (st.n_eff - CNT_W'(1)));

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.latch = 1'b1;
					unique case (action)
						ACT_ADD: begin
							if (st.room) state_d = ST_ADD_LO;
						end
						ACT_QUERY: state_d = ST_INIT;
						ACT_CLEAR: cmd.clear = 1'b1;
						default: ;
					endcase
				end
			end
			ST_ADD_LO: begin
				cmd.add_lo = 1'b1;
				state_d    = ST_ADD_HI;
			end
			ST_ADD_HI: begin
				cmd.add_hi = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_INIT: begin
				cmd.init         = 1'b1;
				cmd.clr_improved = 1'b1;
				edge_idx_d       = '0;
				round_d          = CNT_W'(1);
				check_d          = (st.n_eff == CNT_W'(1));
				state_d          = ST_SCAN;
			end
			ST_SCAN: begin
				if (st.scan_more) begin
					cmd.issue  = 1'b1;
					edge_idx_d = edge_idx_q + EW'(1);
				end else begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_DECIDE;
			ST_DECIDE: begin
				cmd.clr_improved = 1'b1;
				edge_idx_d       = '0;
				out_idx_d        = '0;
				if (check_q) begin
					state_d = st.improved ? ST_NEG : ST_OUT_RD;
				end else if (!st.improved) begin
					// nothing moved this round, distances are final
					state_d = ST_OUT_RD;
				end else if (round_q == st.n_eff - CNT_W'(1)) begin
					check_d = 1'b1;
					state_d = ST_SCAN;
				end else begin
					round_d = round_q + CNT_W'(1);
					state_d = ST_SCAN;
				end
			end
			ST_OUT_RD: state_d = ST_OUT_WR;
			ST_OUT_WR: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					if (cmd.last) begin
						state_d = ST_IDLE;
					end else begin
						out_idx_d = out_idx_q + VTX_W'(1);
						state_d   = ST_OUT_RD;
					end
				end
			end
			ST_NEG: begin
				if (st.out_free) begin
					cmd.neg_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			edge_idx_q <= '0;
			round_q    <= '0;
			check_q    <= 1'b0;
			out_idx_q  <= '0;
		end else begin
			state_q    <= state_d;
			edge_idx_q <= edge_idx_d;
			round_q    <= round_d;
			check_q    <= check_d;
			out_idx_q  <= out_idx_d;
		end
	end

	`SSSP_ASSERT_NOW(a_load_when_free, clk, arst_n, cmd.out_load || cmd.neg_load, st.out_free)
	`SSSP_ASSERT_NEXT(a_query_busy, clk, arst_n, accept && (action == ACT_QUERY), !s_tready)
	`SSSP_ASSERT_NOW(a_round_bound, clk, arst_n, (state_q == ST_SCAN) && !check_q, round_q < st.n_eff)

endmodule

@@ rtl/single_source_shortest_paths_core.sv @@
// ----------------------------------------------------------------------------
// single_source_shortest_paths_core
// Add edge: one table write per direction. Clear: empties the edge table.
// Query: R <= n relaxation passes of one edge per cycle over the E stored
// edges (edge table read port), then one read and one load per result.
// Results wait in an output register; the next item is taken meanwhile.
// Reset (arst_n low): edge table empty, vertex_count = 16, no result pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Bellman-Ford shortest paths over an undirected graph held as a directed
// edge table. Each query seeds the source and runs relaxation rounds over
// the whole table, stopping early once a round changes nothing, else ending
// in a check pass. A relaxable edge in the check pass means a negative cycle
// is reachable: one beat with negative_cycle set. Otherwise one beat per vertex.
//
// Datapath pipeline per edge: table read -> distance reads -> compare/write.
// The write of one edge is forwarded to the next edge's registered reads.
// Edges with an endpoint at or above the vertex count are skipped.
// Distances compare at 25 bits and store saturated to 24 bits.
module single_source_shortest_paths_core import sssp_pkg::*; #(
	parameter int MAX_DIRECTED_EDGES = 128
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CNT_W-1:0]       cfg_wdata,    // vertex_count
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// first_vertex[3:0], second_vertex[7:4], weight[23:8], source_vertex[27:24]
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic [ACT_W-1:0]       s_tuser,      // action[1:0]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// vertex[3:0], distance[27:4], reachable[28], zero fill [31:29]
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tuser,      // negative_cycle
	output logic                   m_tlast
);

	localparam int EW      = $clog2(MAX_DIRECTED_EDGES + 1);
	localparam int OUT_PAD = OUT_TDATA_W - VTX_W - DIST_W - 1;

	sssp_cmd_t         cmd;
	sssp_status_t      st;
	logic [EW-1:0]     edge_idx;
	logic [VTX_W-1:0]  out_vertex;
	logic [DIST_W-1:0] out_distance;
	logic              out_reachable;

	sssp_ctrl #(
		.MAX_DIRECTED_EDGES(MAX_DIRECTED_EDGES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.action   (s_tuser),
		.st       (st),
		.cmd      (cmd),
		.edge_idx (edge_idx)
	);

	sssp_dp #(
		.MAX_DIRECTED_EDGES(MAX_DIRECTED_EDGES)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_wdata          (cfg_wdata),
		.first_vertex       (s_tdata[VTX_W-1:0]),
		.second_vertex      (s_tdata[2*VTX_W-1:VTX_W]),
		.weight             (s_tdata[2*VTX_W+WEIGHT_W-1:2*VTX_W]),
		.source_vertex      (s_tdata[3*VTX_W+WEIGHT_W-1:2*VTX_W+WEIGHT_W]),
		.cmd                (cmd),
		.edge_idx           (edge_idx),
		.st                 (st),
		.m_tready           (m_tready),
		.m_tvalid           (m_tvalid),
		.out_vertex         (out_vertex),
		.out_distance       (out_distance),
		.out_reachable      (out_reachable),
		.out_negative_cycle (m_tuser),
		.out_last           (m_tlast)
	);

	// beat layout, zero fill to a whole word
	assign m_tdata = {{OUT_PAD{1'b0}}, out_reachable, out_distance, out_vertex};

endmodule
